FILE: rtl/sitoa_pkg.sv
// Package for the signed integer to decimal ASCII core.
// Holds the payload types, character codes and the BCD digit correction.
// No dependencies.
package sitoa_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned NumDigits  = 10;
   localparam int unsigned BcdWidth   = 4 * NumDigits;

   typedef logic signed [ValueWidth-1:0] value_type;
   typedef logic [5:0]                   char_type;
   typedef logic [BcdWidth-1:0]          bcd_type;

   localparam char_type CHAR_MINUS = 6'd45;
   localparam char_type CHAR_ZERO  = 6'd48;

   // Double-dabble correction: every BCD digit of five or more gets three added,
   // so that the following left shift carries correctly into the next digit.
   function automatic bcd_type bcd_adjust(input bcd_type bcd);
      bcd_type res;
      res = bcd;
      for (int i = 0; i < NumDigits; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end
      end
      return res;
   endfunction

endpackage

FILE: rtl/signed_int_to_decimal_ascii_core.sv
// Top level of the signed integer to decimal ASCII core.
// Depends on sitoa_pkg for types, character codes and the BCD correction.
// One module: bit-serial binary to BCD conversion followed by a character sequencer.

// Converts one signed 32-bit integer per input word into its decimal text, one
// ASCII character per output word, most significant digit first. A negative
// value starts with a minus sign, leading zeros are dropped, zero gives a single
// '0', and -2147483648 comes out in full. tlast marks the final character of each
// value. An accepted word is loaded, the shift-add-3 (double-dabble) converter
// moves one magnitude bit into the BCD register per cycle, leading zero digits
// are dropped, and the characters follow at one per cycle while the output side
// is not stalling. The block works on one value at a time; the next value is
// taken as soon as the final character sits in the output register, even while
// that character still waits to be taken. No state is kept between values.
module signed_int_to_decimal_ascii_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  sitoa_pkg::value_type req_tdata,   // [31:0] value (signed)
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [5:0] character, [7:6] zero
   output logic                 rsp_tlast    // last character of the value
);

   import sitoa_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CONV,
      S_SKIP,
      S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [ValueWidth-1:0] mag_ff, mag_in;
   bcd_type    bcd_ff, bcd_in;
   bcd_type    bcd_adj;
   logic       neg_ff, neg_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [3:0] dig_ff, dig_in;
   char_type   char_ff, char_in;
   logic       last_ff, last_in;
   logic       valid_ff, valid_in;

   logic req_fire;
   logic slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   // The output register can take a new character when empty or being drained.
   assign slot_free  = !valid_ff || rsp_tready;
   // Every digit of five or more corrected before the next shift.
   assign bcd_adj    = bcd_adjust(bcd_ff);

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      dig_in   = dig_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_tready;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // Magnitude is taken as unsigned, so the most negative value fits.
               neg_in   = req_tdata[ValueWidth-1];
               mag_in   = req_tdata[ValueWidth-1] ? (ValueWidth'(0) - ValueWidth'(req_tdata))
                                                  : ValueWidth'(req_tdata);
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            // One magnitude bit enters the corrected BCD register per cycle.
            bcd_in = {bcd_adj[BcdWidth-2:0], mag_ff[ValueWidth-1]};
            mag_in = {mag_ff[ValueWidth-2:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(ValueWidth - 1)) begin
               dig_in   = 4'(NumDigits);
               state_in = S_SKIP;
            end
         end
         S_SKIP: begin
            // Drop leading zero digits, but always keep the units digit.
            if (bcd_ff[BcdWidth-1 -: 4] == 4'd0 && dig_ff > 4'd1) begin
               bcd_in = {bcd_ff[BcdWidth-5:0], 4'd0};
               dig_in = dig_ff - 4'd1;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               valid_in = 1'b1;
               if (neg_ff) begin
                  char_in = CHAR_MINUS;
                  last_in = 1'b0;
                  neg_in  = 1'b0;
               end else begin
                  char_in = CHAR_ZERO | {2'b00, bcd_ff[BcdWidth-1 -: 4]};
                  last_in = (dig_ff == 4'd1);
                  bcd_in  = {bcd_ff[BcdWidth-5:0], 4'd0};
                  dig_in  = dig_ff - 4'd1;
                  if (dig_ff == 4'd1) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         neg_ff   <= 1'b0;
         cnt_ff   <= '0;
         dig_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         neg_ff   <= neg_in;
         cnt_ff   <= cnt_in;
         dig_ff   <= dig_in;
      end
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, char_ff};
   assign rsp_tlast  = last_ff;

   // An accepted value always starts a fresh conversion with the bit counter at zero.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_CONV) && (cnt_ff == 5'd0))
      else $error("conversion did not start after an accepted value");

   // Every character presented is a minus sign or a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (char_ff == CHAR_MINUS) ||
                     ((char_ff >= CHAR_ZERO) && (char_ff <= CHAR_ZERO + 6'd9)))
      else $error("character out of range");

   // While digits are dropped or sent, at least the units digit remains.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SKIP || state_ff == S_EMIT) |-> (dig_ff != 4'd0))
      else $error("digit count ran out before the last character");

   // A minus sign is never the final character of a value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && char_ff == CHAR_MINUS) |-> !rsp_tlast)
      else $error("minus sign marked as last character");

endmodule

FILE: bench/tb_signed_int_to_decimal_ascii_core.sv
// Self-checking bench for signed_int_to_decimal_ascii_core: drives signed words,
// predicts the decimal text and checks every character and tlast as it is taken.
// Depends on sitoa_pkg and the core RTL only.
module tb_signed_int_to_decimal_ascii_core;
   timeunit 1ns;
   timeprecision 1ps;

   import sitoa_pkg::*;

   // One expected output word: the ASCII code and the end-of-text marker.
   typedef struct packed {
      char_type character;
      logic     last;
   } text_char_type;

   localparam int IdleLimit   = 3000;  // cycles with no word moving on either side
   localparam int DrainCycles = 60;    // a little over one full conversion
   localparam int HoldCycles  = 400;   // long output stall, several conversions long
   localparam int HoldAfter   = 40;    // values accepted before the long stall starts

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   value_type  req_tdata = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   value_type     values_to_send [$];
   text_char_type expected_text [$];

   logic req_taken = 1'b0;    // the offered value was accepted at the last rising edge
   int   values_sent = 0;
   int   negatives_sent = 0;
   int   chars_checked = 0;
   int   fail_count = 0;
   int   idle_cycles = 0;
   int   holds_done = 0;

   always #1ns clock = ~clock;

   signed_int_to_decimal_ascii_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // Appends the decimal text of one value to the expected characters. The
   // magnitude is formed as an unsigned 32-bit number, so the most negative
   // value maps to 2147483648 without overflow. Digits are peeled off least
   // significant first and then queued in reverse, which drops leading zeros
   // by construction and leaves a single '0' for zero.
   function automatic void predict_text(input value_type value);
      logic [31:0]   magnitude;
      logic [3:0]    digits [10];
      int            count;
      text_char_type item;
      magnitude = value[31] ? (~value + 32'd1) : value;
      count = 0;
      do begin
         digits[count] = 4'(magnitude % 10);
         magnitude = magnitude / 10;
         count++;
      end while (magnitude != 0);
      if (value[31]) begin
         item.character = CHAR_MINUS;
         item.last = 1'b0;
         expected_text.push_back(item);
      end
      for (int i = count - 1; i >= 0; i--) begin
         item.character = char_type'(CHAR_ZERO + digits[i]);
         item.last = (i == 0);
         expected_text.push_back(item);
      end
   endfunction

   // Rising edge: note what was accepted on both sides. An accepted value is
   // turned into its expected text right away; an accepted character is
   // compared with the oldest character still waiting.
   always @(posedge clock) begin
      text_char_type want;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         predict_text(req_tdata);
         void'(values_to_send.pop_front());
         values_sent++;
         if (req_tdata[31]) begin
            negatives_sent++;
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_text.size() == 0) begin
            report_mismatch($sformatf("character 0x%02h with no value pending", rsp_tdata));
         end else begin
            want = expected_text.pop_front();
            chars_checked++;
            if (rsp_tdata !== {2'b00, want.character}) begin
               report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                         rsp_tdata, {2'b00, want.character}));
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch($sformatf("tlast %b, expected %b on character 0x%02h",
                                         rsp_tlast, want.last, want.character));
            end
         end
      end
   end

   // Sender: bursts of back-to-back values separated by random gaps. Once a
   // value is offered it stays on the bus unchanged until it is accepted.
   always @(negedge clock) begin
      int burst_left;
      int gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (req_tvalid && !req_taken) begin
         req_tvalid <= 1'b1;
      end else if (gap_left != 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (values_to_send.size() != 0) begin
         req_tvalid <= 1'b1;
         req_tdata <= values_to_send[0];
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
         end else begin
            burst_left--;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver: picks a new stall style whenever the current one runs out. Once,
   // after some values have gone through, it holds off for a long stretch so
   // that the core fills up and has to push back on its input.
   always @(negedge clock) begin
      int hold_left;
      int mode;
      int mode_left;
      int phase;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         mode = 0;
         mode_left = 0;
         phase = 0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_done == 0 && values_sent >= HoldAfter) begin
         holds_done++;
         hold_left = HoldCycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         phase++;
         case (mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_tready <= (phase % 5) < 2;
            end
         endcase
      end
   end

   // Watchdog: a run in which no word moves for too long has hung.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Timeout: no word moved for %0d cycles", IdleLimit);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus and end of run. The directed part covers zero, the sign, the
   // powers of ten and their neighbors, both ends of the range including the
   // most negative value, and alternating bit patterns. The random part mixes
   // values of a chosen digit count, values next to powers of ten and fully
   // random words.
   initial begin
      int       digit_count;
      int       pick;
      longint   tens;
      longint   lo;
      longint   hi;
      longint   magnitude;
      logic     negative;
      value_type value;

      values_to_send.push_back(32'sd0);
      values_to_send.push_back(32'sd1);
      values_to_send.push_back(-32'sd1);
      values_to_send.push_back(32'sd5);
      values_to_send.push_back(32'sd9);
      values_to_send.push_back(32'sd10);
      values_to_send.push_back(-32'sd10);
      values_to_send.push_back(32'sd99);
      values_to_send.push_back(32'sd100);
      values_to_send.push_back(-32'sd999);
      values_to_send.push_back(32'sd999999999);
      values_to_send.push_back(32'sd1000000000);
      values_to_send.push_back(32'sd1000000001);
      values_to_send.push_back(-32'sd1000000000);
      values_to_send.push_back(32'sd2000000009);
      values_to_send.push_back(32'sh7FFF_FFFF);
      values_to_send.push_back(32'sh8000_0001);
      values_to_send.push_back(32'sh8000_0000);
      values_to_send.push_back(32'sd123456789);
      values_to_send.push_back(-32'sd987654321);
      values_to_send.push_back(32'sh5555_5555);
      values_to_send.push_back(32'shAAAA_AAAA);

      for (int n = 0; n < 200; n++) begin
         pick = $urandom_range(0, 19);
         negative = 1'($urandom_range(0, 1));
         if (pick < 12) begin
            // Uniform over one digit count, so short and long texts are
            // equally likely.
            digit_count = $urandom_range(1, 10);
            tens = 1;
            repeat (digit_count - 1) tens = tens * 10;
            lo = (digit_count == 1) ? 0 : tens;
            hi = (digit_count == 10) ? (negative ? 64'd2147483648 : 64'd2147483647)
                                     : tens * 10 - 1;
            magnitude = lo + (longint'($urandom) % (hi - lo + 1));
            value = negative ? value_type'(-magnitude) : value_type'(magnitude);
         end else if (pick < 15) begin
            tens = 1;
            repeat ($urandom_range(0, 9)) tens = tens * 10;
            magnitude = tens + $urandom_range(0, 2) - 1;
            value = negative ? value_type'(-magnitude) : value_type'(magnitude);
         end else begin
            value = $urandom;
         end
         values_to_send.push_back(value);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (values_to_send.size() != 0 || expected_text.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);

      $display("Converted %0d values (%0d negative) and checked %0d characters,",
               values_sent, negatives_sent, chars_checked);
      $display("with bursty input, varied output stalls and %0d long output hold.",
               holds_done);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
